FILE: design/delay_aware_cwnd_controller_unit_macros.svh
// Assertion macros for the delay-aware congestion window controller.
// Used by the top level only; no other dependencies.
`ifndef DELAY_AWARE_CWND_CONTROLLER_UNIT_MACROS_SVH
`define DELAY_AWARE_CWND_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define DCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dcc_pkg.sv
// Shared types and constants of the delay-aware congestion window controller.
// No dependencies; imported by dcc_div and the top level.
package dcc_pkg;

    localparam int WIN_W   = 20;
    localparam int DLY_W   = 31;
    localparam int ACK_W   = 32;
    localparam int SEG_W   = 16;
    localparam int DEC_W   = 8;
    localparam int NUM_W   = 8;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 2;
    localparam int DIVN_W  = 51;
    localparam int DIVD_W  = 31;
    localparam int CNT_W   = 6;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 40;

    localparam logic [WIN_W-1:0] WIN_MAX      = '1;
    localparam logic [WIN_W-1:0] INIT_WINDOW  = 20'd10;
    localparam logic [WIN_W-1:0] CLAMP_RESET  = 20'd666;
    localparam logic [WIN_W-1:0] MIN_WIN      = 20'd2;
    localparam logic [WIN_W-1:0] DEFAULT_RTTS = 20'd20;
    localparam logic [WIN_W-1:0] START_SS     = 20'd20;
    // ceil(2^21 / 3), exact divide by 3 for 20-bit windows
    localparam logic [WIN_W-1:0] RECIP3       = 20'd699051;
    localparam logic [DLY_W-1:0] NO_SAMPLE    = '1;
    localparam logic [DEC_W-1:0] DEC_MAX      = '1;
    localparam logic [ACK_W-1:0] ACK_MAX      = '1;

    typedef enum logic [1:0] {
        MODE_RTT   = 2'd0,
        MODE_INC   = 2'd1,
        MODE_CONG  = 2'd2,
        MODE_RECOV = 2'd3
    } t_mode;

    localparam logic [CIDX_W-1:0] CFG_NUM_RTT  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BUDGET   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CLAMP    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_INIT_WIN = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quo;
        logic [DIVD_W-1:0] rem;
    } t_div_rsp;

endpackage

FILE: design/dcc_div.sv
// Shared restoring divider, one quotient bit per cycle; zero divisor reads as 1.
// Depends on dcc_pkg.
module dcc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcc_pkg::t_div_req i_req,
    output dcc_pkg::t_div_rsp o_rsp
);
    import dcc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVN_W-1:0] r_quo;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_den;
    logic [DIVD_W:0]   w_shift;
    logic [DIVD_W:0]   w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[DIVN_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVN_W);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= (i_req.divisor == '0) ? DIVD_W'(1) : i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIVN_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DIVD_W-1:0] : w_shift[DIVD_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quo: r_quo, rem: r_rem};

endmodule

FILE: design/delay_aware_cwnd_controller_unit.sv
// Delay-aware congestion window controller: sequencer, state and I/O registers.
// Depends on dcc_pkg, dcc_div and the assertion macro header.
//
// Usage: one event per transfer on the s_axis side (mode, segments acked, RTT
// sample, current cwnd and ssthresh); one result per event on the m_axis side
// (new cwnd and ssthresh). Configuration is a plain write port (enable, index,
// data) and is to be written by the user only while the block is idle; the
// block itself does not enforce this. RTT-sample and recovery events go
// straight from idle to the output push. Increase and congestion events run
// through a 51-step restoring divider shared by all divisions of the event,
// with 1 to 4 divisions per event. One event is processed at a time;
// s_axis_tready is high only while idle.
// Reset (synchronous, active low) restores the controller state and config
// registers to their defaults; the initial window is fixed at 10 segments.
// A stalled m_axis side holds the result in the output register; the next
// event is taken meanwhile and waits at its end until the register frees.
`include "delay_aware_cwnd_controller_unit_macros.svh"

module delay_aware_cwnd_controller_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dcc_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [dcc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // mode[1:0], segments_acked[17:2], rtt_ms[48:18], cwnd_in[68:49],
    // ssthresh_in[88:69], zero fill above
    input  logic [dcc_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // cwnd_out[19:0], ssthresh_out[39:20]
    output logic [dcc_pkg::OUT_W-1:0]  m_axis_tdata
);
    import dcc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_PUSH} t_state;
    typedef enum logic [4:0] {
        ST_I0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_AF, ST_R1, ST_R2, ST_R3,
        ST_FLOOR, ST_C0, ST_C1, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8
    } t_step;

    t_state r_state;
    t_step  r_step;
    t_mode  r_mode;

    logic [NUM_W-1:0] r_num;
    logic [CFG_W-1:0] r_budget;
    logic [WIN_W-1:0] r_clamp;

    logic [WIN_W-1:0] r_alpha, r_inc, r_pmw, r_rtt;
    logic [DEC_W-1:0] r_dec;
    logic             r_min_seen, r_incr, r_first;
    logic [ACK_W-1:0] r_ack;
    logic [DLY_W-1:0] r_last, r_filt, r_min_est, r_epoch;
    logic [DLY_W-1:0] r_h0, r_h1, r_h2;

    logic [SEG_W-1:0] r_segs;
    logic [WIN_W-1:0] r_cw, r_ss, r_t1, r_cmax;
    logic [OUT_W-1:0] r_mdata;
    logic             r_mvalid;
    t_div_req         r_div_req;
    t_div_rsp         w_rsp;

    dcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_rsp)
    );

    // input fields
    logic [1:0]       w_in_mode;
    logic [SEG_W-1:0] w_in_segs;
    logic [DLY_W-1:0] w_in_rtt;
    logic [WIN_W-1:0] w_in_cw, w_in_ss;
    logic             w_take;
    assign w_in_mode = s_axis_tdata[1:0];
    assign w_in_segs = s_axis_tdata[17:2];
    assign w_in_rtt  = s_axis_tdata[48:18];
    assign w_in_cw   = s_axis_tdata[68:49];
    assign w_in_ss   = s_axis_tdata[88:69];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_take = s_axis_tvalid && s_axis_tready;

    // rtt sample
    logic [WIN_W+1:0] w_rs_lim;
    assign w_rs_lim = {2'b0, w_in_ss} + {2'b0, r_alpha} + (WIN_W+2)'(1);

    // increase entry
    logic [WIN_W-1:0] w_ssp, w_rc1, w_rtt_ri;
    logic [WIN_W+1:0] w_ad_lim;
    logic             w_ms_i, w_ad;
    logic [DEC_W-1:0] w_dec1;
    logic [ACK_W:0]   w_ack_sum;
    logic [ACK_W-1:0] w_ack_sat;
    assign w_ssp    = r_first ? START_SS : r_ss;
    assign w_ms_i   = r_min_seen || (r_cw > r_inc) || (r_cw < w_ssp);
    assign w_rc1    = (r_rtt > WIN_W'(1)) ? r_rtt - WIN_W'(1) : '0;
    assign w_ad_lim = {2'b0, w_ssp} + {2'b0, r_alpha} + (WIN_W+2)'(2);
    assign w_ad     = ({2'b0, r_cw} > w_ad_lim) && !w_ms_i && (WIN_W'(r_dec) < w_rc1);
    assign w_dec1   = (r_dec < DEC_MAX) ? r_dec + DEC_W'(1) : r_dec;
    assign w_ack_sum = {1'b0, r_ack} + (ACK_W+1)'(r_segs);
    assign w_ack_sat = w_ack_sum[ACK_W] ? ACK_MAX : w_ack_sum[ACK_W-1:0];
    assign w_rtt_ri = (r_num != '0) ? WIN_W'(r_num) : r_rtt;

    // quotient views
    logic [WIN_W-1:0] w_q_sat, w_q_lo, w_q_lo1;
    assign w_q_sat = (|w_rsp.quo[DIVN_W-1:WIN_W]) ? WIN_MAX : w_rsp.quo[WIN_W-1:0];
    assign w_q_lo  = w_rsp.quo[WIN_W-1:0];
    assign w_q_lo1 = (w_q_lo == '0) ? WIN_W'(1) : w_q_lo;

    // additional decrease
    logic [WIN_W-1:0] w_dp1, w_rc_d1, w_rc_d0, w_inc_cwa, w_inc_2, w_inc_cw, w_sel;
    logic [WIN_W:0]   w_sel2;
    logic [WIN_W-1:0] w_af_alpha;
    assign w_dp1     = WIN_W'(r_dec) + WIN_W'(1);
    assign w_rc_d1   = (r_rtt > w_dp1) ? r_rtt - w_dp1 : '0;
    assign w_rc_d0   = (r_rtt > WIN_W'(r_dec)) ? r_rtt - WIN_W'(r_dec) : '0;
    assign w_inc_cwa = (r_inc > w_q_sat) ? r_inc - w_q_sat : '0;
    assign w_inc_2   = (r_inc > MIN_WIN) ? r_inc - MIN_WIN : '0;
    assign w_inc_cw  = (r_inc > r_cw) ? r_inc - r_cw : '0;
    assign w_sel     = (w_q_lo >= r_t1) ? w_q_lo : r_t1;
    assign w_sel2    = {1'b0, w_sel} + (WIN_W+1)'(2);
    assign w_af_alpha = (r_alpha > r_cw) ? ((r_cw == '0) ? WIN_W'(1) : r_cw) : r_alpha;

    // regular increase
    logic [ACK_W-1:0] w_n;
    logic [WIN_W-1:0] w_room, w_inc_a, w_inc_v, w_newcw, w_asum_sat, w_ri_alpha;
    logic [WIN_W:0]   w_asum;
    logic             w_c1, w_c2, w_c3, w_c4;
    assign w_n      = w_rsp.quo[ACK_W-1:0];
    assign w_room   = r_clamp - r_cw;
    assign w_inc_a  = (w_n > ACK_W'(w_room)) ? w_room : w_n[WIN_W-1:0];
    assign w_inc_v  = (WIN_W'(r_segs) < w_inc_a) ? WIN_W'(r_segs) : w_inc_a;
    assign w_newcw  = r_cw + w_inc_v;
    assign w_asum   = {1'b0, r_alpha} + {1'b0, w_inc_v};
    assign w_asum_sat = w_asum[WIN_W] ? WIN_MAX : w_asum[WIN_W-1:0];
    assign w_c1 = (w_newcw >= r_ss) && (r_cw < r_ss) && (r_inc > r_ss);
    assign w_c2 = ((w_newcw >= r_ss) && (r_cw < r_ss) && (r_inc <= r_ss)) ||
                  ((w_newcw >= r_inc) && (r_cw < r_inc));
    assign w_c3 = (w_newcw > r_inc) && (r_alpha < (w_newcw >> 1));
    assign w_c4 = (w_newcw < r_ss);
    always_comb begin
        w_ri_alpha = r_alpha;
        if (w_c2) begin
            w_ri_alpha = WIN_W'(1);
        end else if (w_c3) begin
            w_ri_alpha = w_asum_sat;
        end else if (w_c4) begin
            w_ri_alpha = w_newcw;
        end
        if (w_ri_alpha == '0) begin
            w_ri_alpha = WIN_W'(1);
        end
    end

    // congestion
    logic             w_ca, w_cb, w_cc, w_cd, w_info;
    logic [WIN_W-1:0] w_cm_d, w_cm_e, w_cmax0, w_ssn_h, w_rtt_nr, w_cw3;
    logic [WIN_W+20:0] w_cw3_p;
    logic [DLY_W:0]   w_avg_sum;
    logic [WIN_W:0]   w_cm2, w_t;
    logic [WIN_W-1:0] w_t_sat, w_incn;
    assign w_ca = (r_alpha == WIN_W'(1)) && (r_cw >= r_inc) && (r_inc > r_ss);
    assign w_cb = (r_alpha >= (r_cw >> 1)) && (r_cw > r_inc);
    assign w_cc = (r_alpha >= r_cw) && (r_cw <= r_ss);
    assign w_cd = ((r_cw > r_inc) || (r_cw < r_ss)) && (r_alpha != WIN_W'(1));
    assign w_cm_d = (r_cw > (r_alpha >> 1)) ? r_cw - (r_alpha >> 1) : '0;
    assign w_cm_e = (r_cw > r_alpha) ? r_cw - r_alpha : '0;
    assign w_cw3_p = {21'b0, r_cw} * {21'b0, RECIP3};
    assign w_cw3   = w_cw3_p[WIN_W+20:21];
    assign w_cmax0 = !r_incr ? r_cw : w_cb ? (r_cw - w_cw3) : w_cc ? (r_cw >> 1) :
                     w_cd ? w_cm_d : w_cm_e;
    assign w_info  = (r_min_est != NO_SAMPLE) && (r_filt != '0);
    assign w_ssn_h = ((r_cmax >> 1) < MIN_WIN) ? MIN_WIN : (r_cmax >> 1);
    assign w_avg_sum = {1'b0, r_filt} + {1'b0, r_min_est};
    assign w_rtt_nr  = (w_q_lo < DEFAULT_RTTS) ? DEFAULT_RTTS : w_q_lo;
    assign w_cm2   = {r_cmax, 1'b0};
    assign w_t     = w_cm2 - {1'b0, r_pmw};
    assign w_t_sat = w_t[WIN_W] ? WIN_MAX : w_t[WIN_W-1:0];
    assign w_incn  = ({1'b0, r_pmw} < w_cm2) ? ((w_t_sat > r_t1) ? w_t_sat : r_t1) : r_t1;

    // shared multiplier
    logic [WIN_W-1:0]  w_mul_b;
    logic [DIVN_W-1:0] w_prod;
    assign w_mul_b = (r_mode == MODE_INC) ? w_ssp : r_cmax;
    assign w_prod  = DIVN_W'(r_min_est) * DIVN_W'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= ST_I0;
            r_mode     <= MODE_RTT;
            r_num      <= '0;
            r_budget   <= '0;
            r_clamp    <= CLAMP_RESET;
            r_alpha    <= INIT_WINDOW;
            r_inc      <= INIT_WINDOW;
            r_pmw      <= INIT_WINDOW;
            r_rtt      <= DEFAULT_RTTS;
            r_dec      <= '0;
            r_min_seen <= 1'b1;
            r_incr     <= 1'b0;
            r_first    <= 1'b1;
            r_ack      <= '0;
            r_last     <= NO_SAMPLE;
            r_filt     <= NO_SAMPLE;
            r_min_est  <= NO_SAMPLE;
            r_epoch    <= NO_SAMPLE;
            r_h0       <= '0;
            r_h1       <= '0;
            r_h2       <= '0;
            r_mvalid   <= 1'b0;
            r_div_req  <= '0;
        end else begin
            if ((r_state == S_PUSH) && (!r_mvalid || m_axis_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUM_RTT:  r_num    <= i_cfg_data[NUM_W-1:0];
                    CFG_BUDGET:   r_budget <= i_cfg_data;
                    CFG_CLAMP:    r_clamp  <= i_cfg_data;
                    CFG_INIT_WIN: ;  // reset value is fixed
                    default:      ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_mode <= t_mode'(w_in_mode);
                        r_segs <= w_in_segs;
                        r_cw   <= w_in_cw;
                        r_ss   <= w_in_ss;
                        unique case (t_mode'(w_in_mode))
                            MODE_RTT: begin
                                r_filt  <= (w_in_rtt < r_last) ? w_in_rtt : r_last;
                                r_last  <= w_in_rtt;
                                if (w_in_rtt <= r_min_est) begin
                                    r_min_est  <= w_in_rtt;
                                    r_epoch    <= w_in_rtt;
                                    r_min_seen <= 1'b1;
                                end else if (w_in_rtt <= r_epoch) begin
                                    r_epoch <= w_in_rtt;
                                    if ({2'b0, w_in_cw} > w_rs_lim) begin
                                        r_min_est  <= w_in_rtt;
                                        r_min_seen <= 1'b1;
                                    end
                                end
                                r_state <= S_PUSH;
                            end
                            MODE_INC: begin
                                r_step  <= ST_I0;
                                r_state <= S_RUN;
                            end
                            MODE_CONG: begin
                                r_step  <= ST_C0;
                                r_state <= S_RUN;
                            end
                            MODE_RECOV: begin
                                r_epoch    <= NO_SAMPLE;
                                r_dec      <= '0;
                                r_min_seen <= 1'b0;
                                r_incr     <= 1'b0;
                                r_state    <= S_PUSH;
                            end
                            default: r_state <= S_PUSH;
                        endcase
                    end
                end

                S_WAIT: begin
                    r_div_req.start <= 1'b0;
                    if (w_rsp.done) begin
                        r_state <= S_RUN;
                    end
                end

                S_PUSH: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mdata  <= {r_ss, r_cw};
                        r_state  <= S_IDLE;
                    end
                end

                S_RUN: begin
                    unique case (r_step)
                        ST_I0: begin
                            r_first    <= 1'b0;
                            r_ss       <= w_ssp;
                            r_min_seen <= w_ms_i;
                            r_div_req.start <= 1'b1;
                            r_state    <= S_WAIT;
                            if (w_ad) begin
                                r_dec <= w_dec1;
                                r_ack <= '0;
                                r_div_req.dividend <= w_prod;
                                r_div_req.divisor  <= r_filt;
                                r_step <= ST_A1;
                            end else begin
                                r_ack <= w_ack_sat;
                                r_rtt <= w_rtt_ri;
                                r_div_req.dividend <= DIVN_W'(r_cw);
                                r_div_req.divisor  <= DIVD_W'(r_alpha);
                                r_step <= ST_R1;
                            end
                        end
                        ST_A1: begin
                            r_div_req.start <= 1'b1;
                            r_state <= S_WAIT;
                            if (w_q_sat > MIN_WIN) begin
                                r_cw <= w_q_sat;
                                r_div_req.dividend <= DIVN_W'(w_inc_cwa);
                                r_div_req.divisor  <= DIVD_W'(w_rc_d1);
                                r_step <= ST_A2;
                            end else begin
                                r_cw       <= MIN_WIN;
                                r_min_seen <= 1'b1;
                                r_div_req.dividend <= DIVN_W'(w_inc_2);
                                r_div_req.divisor  <= DIVD_W'(w_rc_d0);
                                r_step <= ST_A5;
                            end
                        end
                        ST_A2: begin
                            r_t1 <= w_q_lo1;
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= DIVN_W'(r_cw);
                            r_div_req.divisor  <= DIVD_W'(w_rc_d0);
                            r_state <= S_WAIT;
                            r_step  <= ST_A3;
                        end
                        ST_A3: begin
                            if ({1'b0, r_cw} > w_sel2) begin
                                r_cw <= r_cw - w_sel;
                            end else begin
                                r_cw       <= MIN_WIN;
                                r_min_seen <= 1'b1;
                            end
                            if (w_q_lo >= r_t1) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= DIVN_W'(w_inc_cw);
                                r_div_req.divisor  <= DIVD_W'(w_rc_d0);
                                r_state <= S_WAIT;
                                r_step  <= ST_A4;
                            end else begin
                                r_alpha <= r_t1;
                                r_step  <= ST_AF;
                            end
                        end
                        ST_A4, ST_A5: begin
                            r_alpha <= w_q_lo1;
                            r_step  <= ST_AF;
                        end
                        ST_AF: begin
                            r_alpha <= w_af_alpha;
                            if (r_alpha > r_cw) begin
                                r_min_seen <= 1'b1;
                            end
                            r_ss   <= (r_cw > WIN_W'(1)) ? r_cw - WIN_W'(1) : '0;
                            r_step <= ST_FLOOR;
                        end
                        ST_R1: begin
                            r_t1 <= w_q_lo1;
                            if (r_ack >= ACK_W'(w_q_lo1)) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= DIVN_W'(r_ack);
                                r_div_req.divisor  <= DIVD_W'(w_q_lo1);
                                r_state <= S_WAIT;
                                r_step  <= ST_R2;
                            end else begin
                                r_step <= ST_FLOOR;
                            end
                        end
                        ST_R2: begin
                            r_ack  <= ACK_W'(w_rsp.rem);
                            if (r_cw < r_clamp) begin
                                r_cw   <= w_newcw;
                                r_incr <= 1'b1;
                                if (w_c1) begin
                                    r_div_req.start    <= 1'b1;
                                    r_div_req.dividend <= DIVN_W'(r_inc - r_ss);
                                    r_div_req.divisor  <= DIVD_W'(r_rtt);
                                    r_state <= S_WAIT;
                                    r_step  <= ST_R3;
                                end else begin
                                    r_alpha <= w_ri_alpha;
                                    r_step  <= ST_FLOOR;
                                end
                            end else begin
                                r_step <= ST_FLOOR;
                            end
                        end
                        ST_R3: begin
                            r_alpha <= w_q_lo1;
                            r_step  <= ST_FLOOR;
                        end
                        ST_FLOOR: begin
                            r_cw    <= (r_cw < MIN_WIN) ? MIN_WIN : r_cw;
                            r_ss    <= (r_ss < MIN_WIN) ? MIN_WIN : r_ss;
                            r_state <= S_PUSH;
                        end
                        ST_C0: begin
                            r_ack <= '0;
                            if ((r_min_est < r_h0) || (r_min_est < r_h1) ||
                                (r_min_est < r_h2)) begin
                                r_h0 <= '0;
                                r_h1 <= '0;
                                r_h2 <= '0;
                            end else if (r_min_est > r_h0) begin
                                if (r_h0 == '0) begin
                                    r_h0 <= r_min_est;
                                end else if (r_h1 == '0) begin
                                    r_h1 <= r_min_est;
                                end else if (r_min_est > r_h1) begin
                                    if (r_h2 == '0) begin
                                        r_h2 <= r_min_est;
                                    end else if (r_min_est > r_h2) begin
                                        r_min_est <= r_h0;
                                        r_h1 <= '0;
                                        r_h2 <= '0;
                                    end
                                end
                            end
                            if (r_incr && w_ca) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= DIVN_W'(r_inc - r_ss);
                                r_div_req.divisor  <= DIVD_W'(r_rtt);
                                r_state <= S_WAIT;
                                r_step  <= ST_C1;
                            end else begin
                                r_cmax <= w_cmax0;
                                r_step <= ST_C3;
                            end
                        end
                        ST_C1: begin
                            r_cmax <= (r_cw > w_q_lo) ? r_cw - w_q_lo : '0;
                            r_step <= ST_C3;
                        end
                        ST_C3: begin
                            if (w_info) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= w_prod;
                                r_div_req.divisor  <= r_filt;
                                r_state <= S_WAIT;
                                r_step  <= ST_C4;
                            end else begin
                                r_t1   <= w_ssn_h;
                                r_step <= ST_C5;
                            end
                        end
                        ST_C4: begin
                            r_t1   <= (w_q_sat < MIN_WIN) ? MIN_WIN : w_q_sat;
                            r_step <= ST_C5;
                        end
                        ST_C5: begin
                            if (r_num != '0) begin
                                r_rtt  <= WIN_W'(r_num);
                                r_step <= ST_C7;
                            end else if ((r_budget != '0) && w_info) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= DIVN_W'(r_budget);
                                r_div_req.divisor  <= w_avg_sum[DLY_W:1];
                                r_state <= S_WAIT;
                                r_step  <= ST_C6;
                            end else begin
                                r_rtt  <= DEFAULT_RTTS;
                                r_step <= ST_C7;
                            end
                        end
                        ST_C6: begin
                            r_rtt  <= w_rtt_nr;
                            r_step <= ST_C7;
                        end
                        ST_C7: begin
                            r_inc <= w_incn;
                            r_pmw <= r_cmax;
                            r_ss  <= r_t1;
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= DIVN_W'(w_incn - r_t1);
                            r_div_req.divisor  <= DIVD_W'(r_rtt);
                            r_state <= S_WAIT;
                            r_step  <= ST_C8;
                        end
                        ST_C8: begin
                            r_alpha <= w_q_lo1;
                            r_state <= S_PUSH;
                        end
                        default: r_state <= S_PUSH;
                    endcase
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    `DCC_ASSERT_IMP(a_alpha_nz, i_clk, i_rst_n, 1'b1, r_alpha != '0, "alpha is zero")
    `DCC_ASSERT_IMP(a_rtt_nz, i_clk, i_rst_n, 1'b1, r_rtt != '0, "rtt count is zero")
    `DCC_ASSERT_IMP(a_div_wait, i_clk, i_rst_n, w_rsp.done, r_state == S_WAIT, "stray divide")
    `DCC_ASSERT_NXT(a_one_event, i_clk, i_rst_n, w_take, !s_axis_tready, "second event taken")

endmodule
